>>> hw/rtl/btmx_pkg.sv
// ----------------------------------------------------------------------------
// Binary trie maximum-xor package
// Shared widths, status and request codes, and the structs that pass between
// the walker, the node memory and the top level.
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int MAX_NODES = 4096;
	localparam int KEY_BITS  = 32;
	localparam int KEY_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int ENTRY_W   = 2 * NODE_W;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	// One read port and one write port of the node table.
	typedef struct packed {
		logic               rd_en;
		node_t              rd_addr;
		logic               wr_en;
		node_t              wr_addr;
		logic [ENTRY_W-1:0] wr_data;
	} ram_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    max_xor;
	} result_t;

endpackage

>>> hw/rtl/btmx_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request word: request type and key.
// ----------------------------------------------------------------------------
interface btmx_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [btmx_pkg::KEY_W-1:0] key;

	modport source (output valid, req_type, key, input ready);
	modport sink   (input valid, req_type, key, output ready);
endinterface

>>> hw/rtl/btmx_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response word: status and maximum xor.
// ----------------------------------------------------------------------------
interface btmx_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [btmx_pkg::STATUS_W-1:0] status;
	logic [btmx_pkg::KEY_W-1:0]    max_xor;

	modport source (output valid, status, max_xor, input ready);
	modport sink   (input valid, status, max_xor, output ready);
endinterface

>>> hw/rtl/btmx_node_ram.sv
// ----------------------------------------------------------------------------
// Trie node memory
// One entry per node holding the 1-child and 0-child indexes. One write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module btmx_node_ram (
	input  logic                                clk,
	input  btmx_pkg::ram_req_t                  ram_req,
	output logic [btmx_pkg::ENTRY_W-1:0]        rd_data
);

	logic [btmx_pkg::ENTRY_W-1:0] mem [btmx_pkg::MAX_NODES];

	always_ff @(posedge clk) begin
		if (ram_req.wr_en) begin
			mem[ram_req.wr_addr] <= ram_req.wr_data;
		end
		if (ram_req.rd_en) begin
			rd_data <= mem[ram_req.rd_addr];
		end
	end

endmodule

>>> hw/rtl/btmx_walker.sv
// ----------------------------------------------------------------------------
// Trie walker
// Sequencer that walks the trie one level per cycle, allocating nodes for an
// insert and steering towards the opposite bit for a query.
// ----------------------------------------------------------------------------
module btmx_walker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [btmx_pkg::KEY_W-1:0]         key,
	output btmx_pkg::ram_req_t                 ram_req,
	input  logic [btmx_pkg::ENTRY_W-1:0]       rd_data,
	output logic                               res_valid,
	input  logic                               res_ready,
	output btmx_pkg::result_t                  res
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_ALLOC = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                            state_q;
	logic                              req_q;
	logic [btmx_pkg::KEY_W-1:0]        key_q;
	btmx_pkg::node_t                   cur_q;
	logic [btmx_pkg::LVL_W-1:0]        lvl_q;
	logic [btmx_pkg::KEY_W-1:0]        acc_q;
	logic [btmx_pkg::STATUS_W-1:0]     status_q;
	logic [btmx_pkg::CNT_W-1:0]        nodes_used_q;
	logic                              nonempty_q;
	logic                              root_set_q;
	logic                              root_blank_q;

	logic [btmx_pkg::ENTRY_W-1:0]      entry;
	btmx_pkg::node_t                   kid0;
	btmx_pkg::node_t                   kid1;
	btmx_pkg::node_t                   kid_same;
	btmx_pkg::node_t                   kid_opp;
	btmx_pkg::node_t                   new_node;
	logic                              bit_b;
	logic                              last_lvl;
	logic                              pool_short;

	// The root entry reads as empty until it is first written.
	assign entry    = root_blank_q ? '0 : rd_data;
	assign kid0     = entry[btmx_pkg::NODE_W-1:0];
	assign kid1     = entry[btmx_pkg::ENTRY_W-1:btmx_pkg::NODE_W];
	assign bit_b    = key_q[lvl_q];
	assign kid_same = bit_b ? kid1 : kid0;
	assign kid_opp  = bit_b ? kid0 : kid1;
	assign new_node = nodes_used_q[btmx_pkg::NODE_W-1:0];
	assign last_lvl = (lvl_q == '0);
	assign pool_short = (btmx_pkg::CNT_W'(btmx_pkg::MAX_NODES) - nodes_used_q)
		< btmx_pkg::CNT_W'(btmx_pkg::KEY_BITS);

	assign in_ready      = (state_q == ST_IDLE);
	assign res_valid     = (state_q == ST_DONE);
	assign res.status    = status_q;
	assign res.max_xor   = acc_q;

	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_IDLE: begin
				ram_req.rd_en   = in_valid;
				ram_req.rd_addr = '0;
			end
			ST_WALK: begin
				if (req_q == btmx_pkg::REQ_INSERT) begin
					if (kid_same != '0) begin
						ram_req.rd_en   = !last_lvl;
						ram_req.rd_addr = kid_same;
					end else begin
						ram_req.wr_en   = 1'b1;
						ram_req.wr_addr = cur_q;
						ram_req.wr_data = bit_b ? {new_node, kid0} : {kid1, new_node};
					end
				end else begin
					ram_req.rd_en   = !last_lvl && ((kid_opp != '0) || (kid_same != '0));
					ram_req.rd_addr = (kid_opp != '0) ? kid_opp : kid_same;
				end
			end
			ST_ALLOC: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = cur_q;
				ram_req.wr_data = bit_b ? {new_node, btmx_pkg::node_t'(0)}
					: {btmx_pkg::node_t'(0), new_node};
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			req_q        <= btmx_pkg::REQ_INSERT;
			key_q        <= '0;
			cur_q        <= '0;
			lvl_q        <= '0;
			acc_q        <= '0;
			status_q     <= btmx_pkg::STATUS_OK;
			nodes_used_q <= btmx_pkg::CNT_W'(1);
			nonempty_q   <= 1'b0;
			root_set_q   <= 1'b0;
			root_blank_q <= 1'b0;
		end else begin
			if (ram_req.rd_en) begin
				root_blank_q <= (ram_req.rd_addr == '0) && !root_set_q;
			end
			if (ram_req.wr_en && (ram_req.wr_addr == '0)) begin
				root_set_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q    <= req_type;
						key_q    <= key;
						cur_q    <= '0;
						lvl_q    <= btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
						acc_q    <= '0;
						status_q <= btmx_pkg::STATUS_OK;
						if ((req_type == btmx_pkg::REQ_INSERT) && pool_short) begin
							status_q <= btmx_pkg::STATUS_POOL_FULL;
							state_q  <= ST_DONE;
						end else if ((req_type == btmx_pkg::REQ_QUERY) && !nonempty_q) begin
							status_q <= btmx_pkg::STATUS_EMPTY;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (req_q == btmx_pkg::REQ_INSERT) begin
						if (kid_same != '0) begin
							cur_q <= kid_same;
						end else begin
							cur_q        <= new_node;
							nodes_used_q <= nodes_used_q + 1'b1;
						end
						if (last_lvl) begin
							nonempty_q <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							lvl_q <= lvl_q - 1'b1;
							if (kid_same == '0) begin
								state_q <= ST_ALLOC;
							end
						end
					end else begin
						if (kid_opp != '0) begin
							acc_q[lvl_q] <= 1'b1;
							cur_q        <= kid_opp;
						end else begin
							cur_q <= kid_same;
						end
						if (last_lvl || ((kid_opp == '0) && (kid_same == '0))) begin
							state_q <= ST_DONE;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end
				end
				ST_ALLOC: begin
					cur_q        <= new_node;
					nodes_used_q <= nodes_used_q + 1'b1;
					if (last_lvl) begin
						nonempty_q <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/binary_trie_max_xor.sv
// A walking request presents its response word once the 32-level walk through
// the registered node memory read port is done; a rejected insert or a query
// on an empty set goes straight to its response word. The walker takes no new
// request word until it has handed the last response word to the output
// register; while the sink stalls, one further word can be walked, then input is held.
// Reset: asynchronous, active low; the set is empty and only the root exists.
// ----------------------------------------------------------------------------
// Binary trie maximum-xor engine
// Holds a set of 32-bit keys as a binary trie and answers maximum-xor queries.
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
	input  logic         clk,
	input  logic         arst_n,
	btmx_req_if.sink     req,
	btmx_rsp_if.source   rsp
);

	// The walker and the node memory talk over a single request struct. The
	// walker presents the next read address combinationally from the
	// registered read data, so the walk advances one trie level per cycle.
	btmx_pkg::ram_req_t              ram_req;
	logic [btmx_pkg::ENTRY_W-1:0]    rd_data;

	logic                            res_valid;
	logic                            res_ready;
	btmx_pkg::result_t               res;

	// Output register: a finished response word is parked here so that the
	// walker may return to idle and take the next request word while the
	// response side is stalled.
	logic                            rsp_valid_q;
	btmx_pkg::result_t               rsp_q;

	btmx_node_ram u_node_ram (
		.clk     (clk),
		.ram_req (ram_req),
		.rd_data (rd_data)
	);

	btmx_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.key       (req.key),
		.ram_req   (ram_req),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The walker may hand over a word whenever the output register is empty
	// or is being emptied in this very cycle.
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The payload carries no reset; it is qualified by the valid flag.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_q.status;
	assign rsp.max_xor = rsp_q.max_xor;

endmodule
